@@ sv/nahd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the pixel merge rule for the half downsampler.
// No dependencies.
package nahd_pkg;

    // Width of the out_width configuration register.
    localparam int CFG_W = 11;

    // Reset value of out_width.
    localparam logic [CFG_W-1:0] OUT_WIDTH_RESET = 11'd128;

    // Configuration register word indexes.
    localparam logic REG_OUT_WIDTH = 1'b0;

    // One RGBA8888 pixel, red in the low byte.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } px_t;

    // Alpha zero is no data: average two valid pixels, pass a lone valid one,
    // else give all zero.
    function automatic px_t merge_px(input px_t p, input px_t q);
        logic [8:0] sr;
        logic [8:0] sg;
        logic [8:0] sb;
        logic [8:0] sa;
        px_t        res;
        sr  = {1'b0, p.red}   + {1'b0, q.red};
        sg  = {1'b0, p.green} + {1'b0, q.green};
        sb  = {1'b0, p.blue}  + {1'b0, q.blue};
        sa  = {1'b0, p.alpha} + {1'b0, q.alpha};
        res = '0;
        if ((p.alpha != 8'd0) && (q.alpha != 8'd0))
        begin
            res.red   = sr[8:1];
            res.green = sg[8:1];
            res.blue  = sb[8:1];
            res.alpha = sa[8:1];
        end
        else if (p.alpha != 8'd0)
        begin
            res = p;
        end
        else if (q.alpha != 8'd0)
        begin
            res = q;
        end
        return res;
    endfunction

endpackage

@@ sv/nodata_aware_half_downsample.sv @@
`timescale 1ns / 1ps
// 2x2 box downsampler for RGBA8888 that treats alpha zero as no data.
// Depends on nahd_pkg (pixel type, merge function, register constants).
//
//   channel   handshake             payload
//   -------   ---------------       ----------------------------------------
//   input     in_valid / in_stall   frame_start, left_*, right_* (RGBA)
//   output    out_valid / out_stall out_red/green/blue/alpha, row_end
//   config    APB write/read        out_width at byte address 0
//
// One pixel pair is taken every cycle while in_stall is low. Even rows write
// the merged pair into the line memory; odd rows read it back, and the entry
// and the odd pair, held in the merge stage, merge into the output register.
// Each entry is written and read at least one row apart, so no forwarding is
// needed. rst_n clears row, column and valid state; the line memory is not
// cleared. A stalled output backs up one stage and then raises in_stall.
module nodata_aware_half_downsample
    import nahd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              frame_start,
    input  logic [7:0]        left_red,
    input  logic [7:0]        left_green,
    input  logic [7:0]        left_blue,
    input  logic [7:0]        left_alpha,
    input  logic [7:0]        right_red,
    input  logic [7:0]        right_green,
    input  logic [7:0]        right_blue,
    input  logic [7:0]        right_alpha,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic [7:0]        out_alpha,
    output logic              row_end
);

    localparam int AW   = $clog2(MAX_OUT_WIDTH + 1);
    localparam int CMPW = (AW > CFG_W) ? AW : CFG_W;
    localparam int CW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    logic [CFG_W-1:0] out_width_reg;
    logic [CW-1:0]    col_reg;
    logic             odd_reg;

    logic             s1_valid_reg;
    px_t              s1_pair_reg;
    logic             s1_last_reg;
    px_t              rd_data_reg;

    logic             out_valid_reg;
    px_t              out_px_reg;
    logic             row_end_reg;

    px_t              mem [MAX_OUT_WIDTH];

    logic             cfg_wr;
    logic [CMPW-1:0]  ow_ext;
    logic [CMPW-1:0]  eff_w;
    logic [CW-1:0]    last_col;
    logic [CW-1:0]    cur_col;
    logic             cur_odd;
    logic             cur_last;
    logic             in_acc;
    logic             out_free;
    px_t              left_px;
    px_t              right_px;
    px_t              pair;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_OUT_WIDTH)
        begin
            prdata = 32'(out_width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg <= OUT_WIDTH_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_OUT_WIDTH))
        begin
            out_width_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Zero acts as one; clamp to the line memory depth.
    always_comb
    begin
        ow_ext = CMPW'(out_width_reg);
        if (out_width_reg == '0)
        begin
            eff_w = CMPW'(1);
        end
        else if (ow_ext > CMPW'(MAX_OUT_WIDTH))
        begin
            eff_w = CMPW'(MAX_OUT_WIDTH);
        end
        else
        begin
            eff_w = ow_ext;
        end
        last_col = CW'(eff_w - CMPW'(1));
    end

    // ---------------- input stage ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        left_px  = '{alpha: left_alpha,  blue: left_blue,  green: left_green,
                     red: left_red};
        right_px = '{alpha: right_alpha, blue: right_blue, green: right_green,
                     red: right_red};
        pair     = merge_px(left_px, right_px);

        cur_col = frame_start ? '0 : col_reg;
        cur_odd = frame_start ? 1'b0 : odd_reg;
        // saturate when the width shrank under the current column
        if (cur_col > last_col)
        begin
            cur_col = last_col;
        end
        cur_last = (cur_col == last_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            odd_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            col_reg <= cur_last ? '0 : CW'(cur_col + CW'(1));
            odd_reg <= cur_last ? !cur_odd : cur_odd;
        end
    end

    // Line memory: write on even rows, read on odd rows.
    always_ff @(posedge clk)
    begin
        if (in_acc && !cur_odd)
        begin
            mem[cur_col] <= pair;
        end
        if (in_acc && cur_odd)
        begin
            rd_data_reg <= mem[cur_col];
        end
    end

    // ---------------- merge stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc && cur_odd)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cur_odd)
        begin
            s1_pair_reg <= pair;
            s1_last_reg <= cur_last;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_px_reg  <= merge_px(rd_data_reg, s1_pair_reg);
            row_end_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_px_reg.red;
    assign out_green = out_px_reg.green;
    assign out_blue  = out_px_reg.blue;
    assign out_alpha = out_px_reg.alpha;
    assign row_end   = row_end_reg;

endmodule

@@ sv/nahd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the half downsampler, bound to the top level.
// Depends only on the top level's ports.
module nahd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       row_end
);

    // hold valid, alpha and row_end of a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_alpha) && $stable(row_end))
        else $error("stalled output transaction changed");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // no-data results are all zero
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_alpha == 8'd0) |->
            (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))
        else $error("no-data output pixel carries color");

    // free output drains or refills, never stalls input next cycle alone
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |=> !in_stall || $past(in_valid) || out_valid)
        else $error("input stalled after free output cycle");

endmodule

bind nodata_aware_half_downsample nahd_checker u_nahd_checker (.*);

@@ sim/nodata_aware_half_downsample_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nodata_aware_half_downsample: queue-fed driver, clocked
// monitor and a cycle-free predictor of the 2x2 no-data aware merge and line store.
// Depends on nahd_pkg (px_t, CFG_W, OUT_WIDTH_RESET, REG_OUT_WIDTH) and the block itself.
module nodata_aware_half_downsample_tb;
    import nahd_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic frame_start;
        px_t  left;
        px_t  right;
    } src_pair_t;

    typedef struct packed {
        px_t  px;
        logic row_end;
    } dn_pix_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    src_pair_t   drv_pair  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        row_end;

    src_pair_t   src_pair_q[$];
    dn_pix_t     downsampled_q[$];

    // predictor state
    logic [CFG_W-1:0] cfg_width = OUT_WIDTH_RESET;
    int               col_pos   = 0;
    logic             odd_row   = 1'b0;
    px_t              line_mem [LINE_DEPTH];

    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    logic hold_req     = 1'b0;
    logic hold_on      = 1'b0;
    int   mismatch_cnt = 0;
    int   quiet_cycles = 0;

    nodata_aware_half_downsample #(
        .MAX_OUT_WIDTH (LINE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (drv_pair.frame_start),
        .left_red    (drv_pair.left.red),
        .left_green  (drv_pair.left.green),
        .left_blue   (drv_pair.left.blue),
        .left_alpha  (drv_pair.left.alpha),
        .right_red   (drv_pair.right.red),
        .right_green (drv_pair.right.green),
        .right_blue  (drv_pair.right.blue),
        .right_alpha (drv_pair.right.alpha),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .row_end     (row_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Average two valid pixels per channel, pass a lone valid one, else all zero.
    function automatic px_t blend_px(input px_t a, input px_t b);
        logic [31:0] av;
        logic [31:0] bv;
        logic [31:0] mv;
        av = a;
        bv = b;
        mv = '0;
        if (a.alpha != 8'd0 && b.alpha != 8'd0)
        begin
            for (int ch = 0; ch < 4; ch++)
                mv[8*ch +: 8] = 8'((int'(av[8*ch +: 8]) + int'(bv[8*ch +: 8])) / 2);
        end
        else if (a.alpha != 8'd0)
            mv = av;
        else if (b.alpha != 8'd0)
            mv = bv;
        return px_t'(mv);
    endfunction

    task automatic downsample_pair(input src_pair_t sp);
        int      eff_w;
        int      col;
        logic    last;
        px_t     merged;
        dn_pix_t pix;
        eff_w = int'(cfg_width);
        if (eff_w == 0)
            eff_w = 1;
        if (eff_w > LINE_DEPTH)
            eff_w = LINE_DEPTH;
        if (sp.frame_start)
        begin
            col_pos = 0;
            odd_row = 1'b0;
        end
        // shrunk width: the pair lands on the last column and closes the row
        if (col_pos >= eff_w)
            col_pos = eff_w - 1;
        col    = col_pos;
        last   = (col + 1) >= eff_w;
        merged = blend_px(sp.left, sp.right);
        if (!odd_row)
            line_mem[col] = merged;
        else
        begin
            pix.px      = blend_px(line_mem[col], merged);
            pix.row_end = last;
            downsampled_q.push_back(pix);
        end
        if (last)
        begin
            col_pos = 0;
            odd_row = ~odd_row;
        end
        else
            col_pos = col + 1;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_pixel();
        dn_pix_t got;
        dn_pix_t want;
        got.px.red    = out_red;
        got.px.green  = out_green;
        got.px.blue   = out_blue;
        got.px.alpha  = out_alpha;
        got.row_end   = row_end;
        if (downsampled_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected pixel rgba=%h row_end=%b",
                                      got.px, got.row_end));
            return;
        end
        want = downsampled_q.pop_front();
        if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
            got.px.blue !== want.px.blue || got.px.alpha !== want.px.alpha ||
            got.row_end !== want.row_end)
            report_mismatch($sformatf(
                "exp r=%0d g=%0d b=%0d a=%0d end=%b, got r=%0d g=%0d b=%0d a=%0d end=%b",
                want.px.red, want.px.green, want.px.blue, want.px.alpha, want.row_end,
                got.px.red, got.px.green, got.px.blue, got.px.alpha, got.row_end));
    endtask

    // Driver: on acceptance predict the pair, then offer the next one or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                downsample_pair(drv_pair);
            if (!in_valid || !in_stall)
            begin
                if (src_pair_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    drv_pair <= src_pair_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transaction and stall at random or during the hold.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_pixel();
            out_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Long receiver hold-off so the block backs up into in_stall.
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nodata_aware_half_downsample_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_OUT_WIDTH, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_width(input logic [CFG_W-1:0] w);
        logic [31:0] rd;
        apb_access(1'b1, 32'(w), rd);
        cfg_width = w;
        apb_access(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== w)
            report_mismatch($sformatf("out_width reads %0d, wrote %0d", rd[CFG_W-1:0], w));
    endtask

    function automatic px_t rgba(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] a);
        px_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        return p;
    endfunction

    function automatic px_t rand_px();
        logic [7:0] a;
        case ($urandom_range(7))
            0, 1:    a = 8'd0;
            2:       a = 8'd255;
            default: a = 8'($urandom_range(255, 1));
        endcase
        return rgba(8'($urandom), 8'($urandom), 8'($urandom), a);
    endfunction

    function automatic void queue_pair(input logic fs, input px_t l, input px_t r);
        src_pair_t sp;
        sp.frame_start = fs;
        sp.left        = l;
        sp.right       = r;
        src_pair_q.push_back(sp);
    endfunction

    // Pairs of random pixels; the first restarts the frame if restart is set, and noise_pct percent restart it mid-row.
    task automatic queue_pairs(input int n, input logic restart, input int noise_pct);
        @(negedge clk);
        for (int i = 0; i < n; i++)
            queue_pair((i == 0 && restart) || ($urandom_range(99) < noise_pct),
                       rand_px(), rand_px());
    endtask

    task automatic drain();
        while (src_pair_q.size() != 0 || in_valid || downsampled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 75)
            return CFG_W'($urandom_range(8, 1));
        return CFG_W'($urandom_range(40, 9));
    endfunction

    task automatic random_rows(input int count);
        repeat (count)
        begin
            set_width(pick_width());
            queue_pairs($urandom_range(24, 16), 1'b1, 3);
            drain();
        end
    endtask

    initial
    begin
        logic [31:0] rd;
        tx_idle_pct = 27;
        rx_idle_pct = 88;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== OUT_WIDTH_RESET)
            report_mismatch($sformatf("out_width after reset reads %0d", rd[CFG_W-1:0]));

        // zero width acts as one column: every pair of items gives a pixel
        set_width('0);
        @(negedge clk);
        queue_pair(1'b1, rgba(255, 255, 255, 255), rgba(255, 255, 255, 255));
        queue_pair(1'b0, rgba(0, 0, 0, 1), rgba(255, 255, 255, 255));
        queue_pair(1'b0, rgba(12, 34, 56, 0), rgba(1, 2, 3, 200));
        queue_pair(1'b0, rgba(9, 8, 7, 6), rgba(0, 0, 0, 0));
        queue_pair(1'b0, rgba(255, 255, 255, 0), rgba(255, 255, 255, 0));
        queue_pair(1'b0, rgba(255, 0, 255, 0), rgba(0, 255, 0, 0));
        queue_pair(1'b0, rgba(1, 1, 1, 1), rgba(0, 0, 0, 0));
        queue_pair(1'b0, rgba(200, 100, 50, 0), rgba(7, 7, 7, 0));
        queue_pair(1'b0, rgba(0, 0, 0, 0), rgba(0, 0, 0, 0));
        queue_pair(1'b0, rgba(254, 255, 0, 128), rgba(255, 254, 1, 127));
        queue_pair(1'b0, rgba(40, 50, 60, 70), rgba(80, 90, 100, 110));
        // restart before the odd row: drop the stored row without output
        queue_pair(1'b1, rgba(0, 255, 0, 255), rgba(255, 0, 255, 0));
        queue_pair(1'b0, rgba(128, 128, 128, 255), rgba(3, 5, 7, 9));
        drain();

        // shrink mid-row: column saturates and the next pair closes the row
        set_width(CFG_W'(6));
        queue_pairs(4, 1'b1, 0);
        drain();
        set_width(CFG_W'(2));
        queue_pairs(3, 1'b0, 0);
        drain();

        // change width between rows and read back entries of the earlier row
        set_width(CFG_W'(4));
        queue_pairs(4, 1'b1, 0);
        drain();
        set_width(CFG_W'(3));
        queue_pairs(3, 1'b0, 0);
        drain();

        random_rows(3);

        @(negedge clk);
        tx_idle_pct = 88;
        rx_idle_pct = 27;
        random_rows(3);

        @(negedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_width(CFG_W'(2));
        @(negedge clk);
        hold_req = 1'b1;
        queue_pairs(200, 1'b1, 0);
        drain();

        // oversized width clamps to the line depth: item 1025 starts the odd row
        set_width(CFG_W'(2047));
        queue_pairs(LINE_DEPTH + 1, 1'b1, 0);
        drain();
        set_width(CFG_W'(1));
        queue_pairs(1, 1'b0, 0);
        drain();
        set_width(CFG_W'(LINE_DEPTH));
        queue_pairs(40, 1'b1, 0);
        drain();

        random_rows(2);

        if (mismatch_cnt == 0 && downsampled_q.size() == 0)
            $display("nodata_aware_half_downsample_tb: PASS");
        else
            $display("nodata_aware_half_downsample_tb: FAIL");
        $finish;
    end

endmodule

@@ nodata_aware_half_downsample.f @@
sv/nahd_pkg.sv
sv/nodata_aware_half_downsample.sv
sv/nahd_checker.sv
sim/nodata_aware_half_downsample_tb.sv
